/* rtl/blf_pkg.sv */
// Shared types, constants and helper functions for the binary log framer.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package blf_pkg;

    // Frame layout
    localparam int HDR_LEN       = 28;
    localparam int IDX_W         = 5;
    localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HDR_LEN - 1);
    localparam logic [7:0]  PREAMBLE_0 = 8'hAA;
    localparam logic [7:0]  PREAMBLE_1 = 8'h44;
    localparam logic [7:0]  PREAMBLE_2 = 8'h12;
    localparam logic [7:0]  HDR_LEN_BYTE = 8'(HDR_LEN);
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

    // Payload length limit (length field is 8 bits wide)
    localparam logic [15:0] MAX_PAYLOAD = 16'd255;

    // Command queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        FUNC_START = 1'b0,
        FUNC_BYTE  = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_HDR,
        BK_CRC
    } back_state_t;

    // One classified command for the back end
    typedef struct packed
    {
        func_t       kind;            // start of frame or payload byte
        logic        last;            // CRC trailer follows this command
        logic [15:0] message_id;
        logic [7:0]  payload_length;  // already saturated
        logic [15:0] sequence_num;
        logic [15:0] week;
        logic [31:0] tow_ms;
        logic [7:0]  payload_byte;
    } cmd_t;

    // Fold one byte into the reflected CRC-32
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = {24'd0, crc[7:0] ^ b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return {8'd0, crc[31:8]} ^ c;
    endfunction

    // Header byte at a given offset
    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx, input cmd_t cmd);
        logic [7:0] b;
        case (idx)
            5'd0:    b = PREAMBLE_0;
            5'd1:    b = PREAMBLE_1;
            5'd2:    b = PREAMBLE_2;
            5'd3:    b = HDR_LEN_BYTE;
            5'd4:    b = cmd.message_id[7:0];
            5'd5:    b = cmd.message_id[15:8];
            5'd8:    b = cmd.payload_length;
            5'd10:   b = cmd.sequence_num[7:0];
            5'd11:   b = cmd.sequence_num[15:8];
            5'd14:   b = cmd.week[7:0];
            5'd15:   b = cmd.week[15:8];
            5'd16:   b = cmd.tow_ms[7:0];
            5'd17:   b = cmd.tow_ms[15:8];
            5'd18:   b = cmd.tow_ms[23:16];
            5'd19:   b = cmd.tow_ms[31:24];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

/* rtl/blf_front.sv */
// Front end: accepts input words, tracks the open frame and sequence number,
// and turns each word into a command (or drops it). Depends on blf_pkg.
module blf_front
    import blf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  func_t       func,
    input  logic [15:0] message_id,
    input  logic [7:0]  payload_length,
    input  logic [15:0] week,
    input  logic [31:0] tow_ms,
    input  logic [7:0]  payload_byte,
    output logic        push,
    output cmd_t        cmd
);

    logic        frame_open_reg, frame_open_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] seq_reg, seq_next;
    logic [7:0]  len_sat;
    logic        is_last_byte;

    // Clamp the requested length
    assign len_sat = ({8'd0, payload_length} > MAX_PAYLOAD) ? MAX_PAYLOAD[7:0]
                                                            : payload_length;
    assign is_last_byte = (bytes_left_reg == 8'd1);

    // Classify and update frame tracking
    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        seq_next        = seq_reg;
        push            = 1'b0;

        cmd.kind           = func;
        cmd.last           = 1'b0;
        cmd.message_id     = message_id;
        cmd.payload_length = len_sat;
        cmd.sequence_num   = seq_reg + 16'd1;
        cmd.week           = week;
        cmd.tow_ms         = tow_ms;
        cmd.payload_byte   = payload_byte;

        if (in_fire)
        begin
            case (func)
                FUNC_START:
                begin
                    push            = 1'b1;
                    cmd.last        = (len_sat == 8'd0);
                    seq_next        = seq_reg + 16'd1;
                    bytes_left_next = len_sat;
                    frame_open_next = (len_sat != 8'd0);
                end
                FUNC_BYTE:
                begin
                    if (frame_open_reg)
                    begin
                        push            = 1'b1;
                        cmd.last        = is_last_byte;
                        bytes_left_next = bytes_left_reg - 8'd1;
                        frame_open_next = !is_last_byte;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 8'd0;
            seq_reg        <= 16'd0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
            seq_reg        <= seq_next;
        end
    end

endmodule

/* rtl/blf_queue.sv */
// Short command queue between the front and back end.
// Depends on blf_pkg for the command type and depth.
module blf_queue
    import blf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* rtl/blf_back.sv */
// Back end: runs each command, emitting header, payload and CRC bytes
// through a registered output stage. Depends on blf_pkg.
module blf_back
    import blf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       frame_end,
    output logic       run_end
);

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      crc_reg, crc_next;
    cmd_t             cmd_reg, cmd_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             frame_end_reg, frame_end_next;
    logic             run_end_reg, run_end_next;
    logic             advance;
    logic [7:0]       hdr_b;
    logic [7:0]       crc_b;

    assign advance = !out_valid_reg || out_ready;

    // Header byte for the current offset (offset 0 comes straight off the queue)
    assign hdr_b = (state_reg == BK_IDLE) ? hdr_byte('0, head) : hdr_byte(idx_reg, cmd_reg);
    assign crc_b = crc_reg[{idx_reg[1:0], 3'b000} +: 8];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        frame_end_next = frame_end_reg;
        run_end_next   = run_end_reg;
        pop            = 1'b0;

        if (advance)
        begin
            case (state_reg)
                BK_IDLE:
                begin
                    if (!empty)
                    begin
                        pop            = 1'b1;
                        cmd_next       = head;
                        out_valid_next = 1'b1;
                        frame_end_next = 1'b0;
                        if (head.kind == FUNC_START)
                        begin
                            out_byte_next = hdr_b;
                            crc_next      = crc_fold(32'd0, hdr_b);
                            idx_next      = IDX_W'(1);
                            run_end_next  = 1'b0;
                            state_next    = BK_HDR;
                        end
                        else
                        begin
                            out_byte_next = head.payload_byte;
                            crc_next      = crc_fold(crc_reg, head.payload_byte);
                            idx_next      = '0;
                            run_end_next  = !head.last;
                            state_next    = head.last ? BK_CRC : BK_IDLE;
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                    end
                end
                BK_HDR:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = hdr_b;
                    frame_end_next = 1'b0;
                    crc_next       = crc_fold(crc_reg, hdr_b);
                    run_end_next   = 1'b0;
                    if (idx_reg == HDR_LAST)
                    begin
                        idx_next     = '0;
                        run_end_next = !cmd_reg.last;
                        state_next   = cmd_reg.last ? BK_CRC : BK_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                BK_CRC:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = crc_b;
                    frame_end_next = (idx_reg[1:0] == 2'd3);
                    run_end_next   = (idx_reg[1:0] == 2'd3);
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg[1:0] == 2'd3)
                        state_next = BK_IDLE;
                end
                default:
                begin
                    state_next = BK_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            crc_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        out_byte_reg  <= out_byte_next;
        frame_end_reg <= frame_end_next;
        run_end_reg   <= run_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign run_end   = run_end_reg;

endmodule

/* rtl/binary_log_framer_crc32.sv */
// Top level of the binary log framer: front end, command queue, back end.
// Depends on blf_pkg, blf_front, blf_queue and blf_back.
//
// Frames binary log messages into a byte stream with a reflected CRC-32
// trailer. A start word emits a 28-byte header, plus the 4 CRC bytes at once
// when the payload is empty; each payload byte emits one byte, plus the 4 CRC
// bytes after the last one. Input words are taken one per cycle while the
// two-entry command queue has room; the output side delivers one byte per
// cycle while m_tready is high, so a start word occupies the back end for 28
// (or 32) output bytes, a payload byte for one and a final payload byte for
// five. Bytes outside an open frame are accepted and dropped.
module binary_log_framer_crc32
    import blf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] message_id, [23:16] payload_length, [39:24] week,
    // [71:40] tow_ms, [79:72] payload_byte
    input  logic [79:0] s_tdata,
    // [0] func
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // [0] run_end
    output logic [0:0]  m_tuser
);

    logic in_fire;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t front_cmd;
    cmd_t q_head;
    logic run_end;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    // Classify input words
    blf_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .func           (func_t'(s_tuser[0])),
        .message_id     (s_tdata[15:0]),
        .payload_length (s_tdata[23:16]),
        .week           (s_tdata[39:24]),
        .tow_ms         (s_tdata[71:40]),
        .payload_byte   (s_tdata[79:72]),
        .push           (q_push),
        .cmd            (front_cmd)
    );

    // Decouple front and back
    blf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Emit header, payload and CRC bytes
    blf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .frame_end (m_tlast),
        .run_end   (run_end)
    );

    assign m_tuser[0] = run_end;

`ifndef SYNTHESIS
    // Back end never pops an empty queue
    assert_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // Front end never pushes into a full queue
    assert_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    // A frame's last CRC byte always closes the run of its input word
    assert_frame_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("frame end without run end");

    // A push into an empty queue that is not drained leaves it non-empty
    assert_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_pop |=> !q_empty)
        else $error("pushed command lost");
`endif

endmodule
